/* rtl/core/lers_pkg.sv */
`timescale 1ns / 1ps

package lers_pkg;

  localparam int IMAGE_DIM = 1024;
  localparam int COL_W     = 10;
  localparam int EDGE_W    = COL_W + 1;
  localparam int GAP_W     = COL_W + 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  typedef logic [COL_W-1:0]  col_t;
  typedef logic [EDGE_W-1:0] edge_t;
  typedef logic [GAP_W-1:0]  gap_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_LEFT  = 2'd0,
    CFG_SCAN_RIGHT = 2'd1,
    CFG_MIN_GAP    = 2'd2,
    CFG_MAX_GAP    = 2'd3
  } cfg_idx_t;

  localparam col_t  SCAN_LEFT_RST  = col_t'(200);
  localparam edge_t SCAN_RIGHT_RST = edge_t'(600);
  localparam col_t  MIN_GAP_RST    = col_t'(50);
  localparam col_t  MAX_GAP_RST    = col_t'(100);

endpackage

/* rtl/core/lane_edge_row_scanner.sv */
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Word
// in_      input      in_valid / in_ready   pixel_on, col, row, frame_first
// out_     output     out_valid / out_ready lane_row, left_x, right_x, mid_x, one_line
// cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One pixel word is taken every clock while in_ready is high; the row state updates at the edge that accepts it.
// A result appears in the output register in the cycle after the pixel that completes the row is accepted.
// Throughput is one word per cycle, limited only by the single output register.
// The input stalls only while a result sits in the output register and out_ready is low.
// Reset is synchronous on rst_n and restores the register defaults and clears row state.

module lane_edge_row_scanner
  import lers_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_pixel_on,
  input  logic [COL_W-1:0]     in_col,
  input  logic [COL_W-1:0]     in_row,
  input  logic                 in_frame_first,

  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [COL_W-1:0]     out_lane_row,
  output logic [COL_W-1:0]     out_left_x,
  output logic [COL_W-1:0]     out_right_x,
  output logic [COL_W-1:0]     out_mid_x,
  output logic                 out_one_line,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  col_t  scan_left_r;
  edge_t scan_right_r;
  col_t  min_gap_r;
  col_t  max_gap_r;

  logic  prev_pixel_r, prev_pixel_nxt;
  logic  left_found_r, left_found_nxt;
  col_t  left_col_r, left_col_nxt;
  col_t  left_report_r, left_report_nxt;
  logic  fb_found_r, fb_found_nxt;
  col_t  fb_col_r, fb_col_nxt;
  logic  row_done_r, row_done_nxt;

  logic  out_valid_r, out_valid_nxt;
  col_t  lane_row_r, left_x_r, right_x_r, mid_x_r;
  logic  one_line_r;
  col_t  right_sel;
  logic  one_line_sel;

  logic  accept;
  logic  prev_eff, left_found_eff, fb_found_eff, row_done_eff;
  logic  row_start, in_win, disabled;
  logic  rising, falling, at_last, edge_right;
  gap_t  gap;
  logic  beyond_max, beyond_min;
  logic  is_left, is_move, is_match, is_fall, is_fb;
  edge_t mid_sum;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prev_eff       = in_frame_first ? 1'b0 : prev_pixel_r;
    row_start      = in_frame_first || (in_col == scan_left_r);
    left_found_eff = row_start ? 1'b0 : left_found_r;
    fb_found_eff   = row_start ? 1'b0 : fb_found_r;
    row_done_eff   = row_start ? 1'b0 : row_done_r;

    in_win = (in_col >= scan_left_r) && ({1'b0, in_col} < scan_right_r)
             && ({1'b0, in_col} < edge_t'(IMAGE_DIM));
    disabled = (min_gap_r == '0) || (max_gap_r == '0);

    rising     = !prev_eff && in_pixel_on;
    falling    = prev_eff && !in_pixel_on;
    at_last    = ({1'b0, in_col} + edge_t'(1)) == scan_right_r;
    edge_right = falling || (at_last && in_pixel_on);
    gap        = {2'b00, in_col} - {2'b00, left_col_r};
    beyond_max = $signed(gap) > $signed({2'b00, max_gap_r});
    beyond_min = $signed(gap) > $signed({2'b00, min_gap_r});

    is_left  = (rising || ((in_col == scan_left_r) && in_pixel_on)) && !left_found_eff;
    is_move  = !is_left && edge_right && left_found_eff && beyond_max;
    is_match = !is_left && !is_move && edge_right && left_found_eff && beyond_min;
    is_fall  = !is_left && !is_move && !is_match && falling;
    is_fb    = !is_left && !is_move && !is_match && !is_fall && at_last
               && left_found_eff && fb_found_eff && (fb_col_r > left_col_r);

    prev_pixel_nxt  = prev_eff;
    left_found_nxt  = left_found_eff;
    left_col_nxt    = left_col_r;
    left_report_nxt = left_report_r;
    fb_found_nxt    = fb_found_eff;
    fb_col_nxt      = fb_col_r;
    row_done_nxt    = row_done_eff;

    if (in_win && !row_done_eff) begin
      if (disabled) begin
        prev_pixel_nxt = in_pixel_on;
      end else begin
        if (!is_match) begin
          prev_pixel_nxt = in_pixel_on;
        end
        if (is_left) begin
          left_found_nxt  = 1'b1;
          left_col_nxt    = in_col;
          left_report_nxt = in_col;
        end
        if (is_move) begin
          left_report_nxt = in_col;
        end
        if (is_fall) begin
          fb_found_nxt = 1'b1;
          fb_col_nxt   = in_col;
        end
        if (is_match || is_fb) begin
          row_done_nxt = 1'b1;
        end
      end
    end

    right_sel    = is_fb ? fb_col_r : in_col;
    one_line_sel = is_fb;
    mid_sum      = {1'b0, left_col_r} + {1'b0, right_sel};
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      out_valid_nxt = in_win && !row_done_eff && !disabled && (is_match || is_fb);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_left_r   <= SCAN_LEFT_RST;
      scan_right_r  <= SCAN_RIGHT_RST;
      min_gap_r     <= MIN_GAP_RST;
      max_gap_r     <= MAX_GAP_RST;
      prev_pixel_r  <= 1'b0;
      left_found_r  <= 1'b0;
      left_col_r    <= '0;
      left_report_r <= '0;
      fb_found_r    <= 1'b0;
      fb_col_r      <= '0;
      row_done_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SCAN_LEFT:  scan_left_r  <= cfg_wdata[COL_W-1:0];
          CFG_SCAN_RIGHT: scan_right_r <= cfg_wdata[EDGE_W-1:0];
          CFG_MIN_GAP:    min_gap_r    <= cfg_wdata[COL_W-1:0];
          CFG_MAX_GAP:    max_gap_r    <= cfg_wdata[COL_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        prev_pixel_r  <= prev_pixel_nxt;
        left_found_r  <= left_found_nxt;
        left_col_r    <= left_col_nxt;
        left_report_r <= left_report_nxt;
        fb_found_r    <= fb_found_nxt;
        fb_col_r      <= fb_col_nxt;
        row_done_r    <= row_done_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lane_row_r <= in_row;
      left_x_r   <= left_report_r;
      right_x_r  <= right_sel;
      mid_x_r    <= mid_sum[EDGE_W-1:1];
      one_line_r <= one_line_sel;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_lane_row = lane_row_r;
  assign out_left_x   = left_x_r;
  assign out_right_x  = right_x_r;
  assign out_mid_x    = mid_x_r;
  assign out_one_line = one_line_r;

`ifndef SYNTH
  a_mid_not_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_mid_x <= out_right_x))
    else $error("mid point lies right of the right edge");

  a_done_has_left: assert property (@(posedge clk) disable iff (!rst_n)
    row_done_r |-> left_found_r)
    else $error("row finished without a left edge");

  a_report_order: assert property (@(posedge clk) disable iff (!rst_n)
    left_found_r |-> (left_report_r >= left_col_r))
    else $error("reported left point lies left of the left edge");

  a_result_from_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted word");
`endif

endmodule
